@@ rtl/rabs_pkg.sv @@
// ----------------------------------------------------------------------------
// rabs_pkg
// Shared types, constants and helpers for the running-average background
// subtraction block.
// ----------------------------------------------------------------------------
package rabs_pkg;

  localparam int unsigned MAX_PIXELS = 524288;
  localparam int unsigned ADDR_W     = 20;
  localparam int unsigned RAM_AW     = $clog2(MAX_PIXELS);
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned ALPHA_W    = 9;
  localparam int unsigned SUM_W      = 10;
  localparam int unsigned PROD_W     = 18;

  typedef logic [PIX_W-1:0]   pix_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [ALPHA_W-1:0] alpha_t;
  typedef logic [SUM_W-1:0]   sum_t;

  localparam alpha_t ALPHA_RESET = alpha_t'(26);
  localparam alpha_t ALPHA_ONE   = alpha_t'(256);
  localparam addr_t  ADDR_SAT    = addr_t'(MAX_PIXELS);

  // floor(s/3) for s <= 765 as (s*683) >> 11
  localparam sum_t        RECIP3       = sum_t'(683);
  localparam int unsigned RECIP3_SHIFT = 11;

  // per-transaction control carried down the pipeline
  typedef struct packed {
    logic  upd;   // background update (store primed), else priming write
    logic  over;  // address beyond store capacity
    logic  eof;
    addr_t addr;
  } tag_t;

  function automatic pix_t gray_of_sum(input sum_t s);
    logic [2*SUM_W-1:0] p;
    p = (2*SUM_W)'(s) * (2*SUM_W)'(RECIP3);
    return p[RECIP3_SHIFT +: PIX_W];
  endfunction

endpackage

@@ rtl/rabs_ram.sv @@
// ----------------------------------------------------------------------------
// rabs_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module rabs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/running_average_background_subtract_top.sv @@
// ----------------------------------------------------------------------------
// running_average_background_subtract_top
// Gray conversion and per-pixel running-average background with motion
// magnitude, over a raster pixel stream.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in_     | input     | in_valid / in_stall     | blue, green, red, sof, eof
//  out_    | output    | out_valid / out_stall   | background, motion, overflow,
//          |           |                         | frame_done
//  cfg_    | input     | cfg_wr_en               | cfg_wr_data (alpha, Q1.8)
//
//  one pixel per clock unless out_stall or an address hazard holds the input;
//  an accepted pixel passes s1, s2, s3 and s4 before out_valid
//  a pixel whose address is still being updated in flight (a frame or a
//  restart of three pixels or fewer) waits for that store write, made as
//  the earlier pixel leaves s3, which a stall on the result side holds back
//  reset is synchronous; the background store is not cleared, the first frame fills it and produces no results
//  out_stall backs up through the pipeline stages to in_stall
// ----------------------------------------------------------------------------
module running_average_background_subtract_top (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  rabs_pkg::pix_t   in_blue,
  input  rabs_pkg::pix_t   in_green,
  input  rabs_pkg::pix_t   in_red,
  input  logic             in_start_of_frame,
  input  logic             in_end_of_frame,
  output logic             out_valid,
  input  logic             out_stall,
  output rabs_pkg::pix_t   out_background,
  output rabs_pkg::pix_t   out_motion,
  output logic             out_overflow,
  output logic             out_frame_done,
  input  logic             cfg_wr_en,
  input  rabs_pkg::alpha_t cfg_wr_data
);
  import rabs_pkg::*;

  // control state
  addr_t  pixel_addr_r, pixel_addr_nxt;
  logic   primed_r, primed_nxt;
  alpha_t alpha_r, alpha_nxt;

  // pipeline
  logic   s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_v_r;
  tag_t   s1_tag_r, s2_tag_r, s3_tag_r, s4_tag_r;
  sum_t   s1_sum_r, s1_sum_nxt;
  pix_t   s2_gray_r, s2_bg_r;
  pix_t   s3_gray_r, s3_bg_r;
  logic signed [PROD_W-1:0] s3_prod_r, s3_prod_nxt;
  pix_t   s4_gray_r, s4_bg_r, s4_bg_nxt;
  pix_t   out_bg_r, out_bg_nxt, out_motion_r, out_motion_nxt;
  logic   out_over_r, out_eof_r;

  logic   out_take, s4_rdy, s3_go, s3_rdy, s2_rdy, s1_rdy;
  logic   in_acc, hazard, over_cur;
  addr_t  addr_cur;
  tag_t   tag_cur;
  pix_t   ram_rdata, ram_wdata, gray_nxt;
  logic   ram_we;
  logic signed [PIX_W:0]   diff;
  logic signed [PIX_W+1:0] bg_wide;

  // stage flow
  assign out_take = !out_v_r || !out_stall;
  assign s4_rdy   = !s4_v_r || out_take;
  // priming transactions leave after their store write
  assign s3_go    = s3_v_r && (!s3_tag_r.upd || s4_rdy);
  assign s3_rdy   = !s3_v_r || s3_go;
  assign s2_rdy   = !s2_v_r || s3_rdy;
  assign s1_rdy   = !s1_v_r || s2_rdy;

  assign addr_cur = in_start_of_frame ? '0 : pixel_addr_r;
  assign over_cur = addr_cur >= ADDR_SAT;

  // read-after-write on an address still in flight
  assign hazard = !over_cur && (
      (s1_v_r && !s1_tag_r.over && s1_tag_r.addr == addr_cur) ||
      (s2_v_r && !s2_tag_r.over && s2_tag_r.addr == addr_cur) ||
      (s3_v_r && !s3_tag_r.over && s3_tag_r.addr == addr_cur));

  assign in_stall = !rst_n || !s1_rdy || hazard;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    tag_cur.upd  = primed_r;
    tag_cur.over = over_cur;
    tag_cur.eof  = in_end_of_frame;
    tag_cur.addr = addr_cur;

    s1_sum_nxt = sum_t'(in_blue) + sum_t'(in_green) + sum_t'(in_red);

    pixel_addr_nxt = pixel_addr_r;
    primed_nxt     = primed_r;
    if (in_acc) begin
      if (in_end_of_frame) begin
        pixel_addr_nxt = '0;
        primed_nxt     = 1'b1;
      end else if (over_cur) begin
        pixel_addr_nxt = ADDR_SAT;
      end else begin
        pixel_addr_nxt = addr_cur + addr_t'(1);
      end
    end

    alpha_nxt = alpha_r;
    if (cfg_wr_en) begin
      alpha_nxt = (cfg_wr_data > ALPHA_ONE) ? ALPHA_ONE : cfg_wr_data;
    end
  end

  // stage 1 -> 2: gray level; stage 2 -> 3: weighted difference, bg' = bg + floor((gray-bg)*alpha/256)
  assign gray_nxt    = gray_of_sum(s1_sum_r);
  assign diff        = $signed({1'b0, s2_gray_r}) - $signed({1'b0, s2_bg_r});
  assign s3_prod_nxt = PROD_W'(diff) * PROD_W'($signed({1'b0, alpha_r}));

  // stage 3 -> 4: new background and store write
  assign bg_wide   = $signed({2'b00, s3_bg_r}) + s3_prod_r[PROD_W-1:PIX_W];
  assign s4_bg_nxt = bg_wide[PIX_W-1:0];
  assign ram_we    = s3_go && !s3_tag_r.over;
  assign ram_wdata = s3_tag_r.upd ? s4_bg_nxt : s3_gray_r;

  // stage 4 -> out: motion magnitude
  always_comb begin
    if (s4_tag_r.over) begin
      out_bg_nxt     = '0;
      out_motion_nxt = '0;
    end else begin
      out_bg_nxt     = s4_bg_r;
      out_motion_nxt = (s4_gray_r >= s4_bg_r) ? s4_gray_r - s4_bg_r
                                              : s4_bg_r - s4_gray_r;
    end
  end

  rabs_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_PIXELS)
  ) u_bg_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (s3_tag_r.addr[RAM_AW-1:0]),
    .wr_data (ram_wdata),
    .rd_en   (in_acc),
    .rd_addr (addr_cur[RAM_AW-1:0]),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_addr_r <= '0;
      primed_r     <= 1'b0;
      alpha_r      <= ALPHA_RESET;
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      s3_v_r       <= 1'b0;
      s4_v_r       <= 1'b0;
      out_v_r      <= 1'b0;
    end else begin
      pixel_addr_r <= pixel_addr_nxt;
      primed_r     <= primed_nxt;
      alpha_r      <= alpha_nxt;
      if (s1_rdy) begin
        s1_v_r <= in_acc;
      end
      if (s2_rdy) begin
        s2_v_r <= s1_v_r;
      end
      if (s3_rdy) begin
        s3_v_r <= s2_v_r;
      end
      if (s4_rdy) begin
        s4_v_r <= s3_v_r && s3_tag_r.upd;
      end
      if (out_take) begin
        out_v_r <= s4_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      s1_tag_r <= tag_cur;
      s1_sum_r <= s1_sum_nxt;
    end
    if (s2_rdy) begin
      s2_tag_r  <= s1_tag_r;
      s2_gray_r <= gray_nxt;
      s2_bg_r   <= ram_rdata;
    end
    if (s3_rdy) begin
      s3_tag_r  <= s2_tag_r;
      s3_gray_r <= s2_gray_r;
      s3_bg_r   <= s2_bg_r;
      s3_prod_r <= s3_prod_nxt;
    end
    if (s4_rdy) begin
      s4_tag_r  <= s3_tag_r;
      s4_gray_r <= s3_gray_r;
      s4_bg_r   <= s4_bg_nxt;
    end
    if (out_take) begin
      out_bg_r     <= out_bg_nxt;
      out_motion_r <= out_motion_nxt;
      out_over_r   <= s4_tag_r.over;
      out_eof_r    <= s4_tag_r.eof;
    end
  end

  assign out_valid      = out_v_r;
  assign out_background = out_bg_r;
  assign out_motion     = out_motion_r;
  assign out_overflow   = out_over_r;
  assign out_frame_done = out_eof_r;

endmodule

@@ rtl/rabs_checker.sv @@
// ----------------------------------------------------------------------------
// rabs_checker
// Port-level checks for the running-average background subtraction block.
// ----------------------------------------------------------------------------
module rabs_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input rabs_pkg::pix_t   out_background,
  input rabs_pkg::pix_t   out_motion,
  input logic             out_overflow,
  input logic             out_frame_done
);
  import rabs_pkg::*;

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_background) &&
      $stable(out_motion) && $stable(out_overflow) && $stable(out_frame_done))
    else $error("result changed while stalled");

  // out of range pixels give an empty result
  a_over_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_background == '0 && out_motion == '0)
    else $error("overflow result carries data");

  // no input taken while in reset
  a_rst_stall: assert property (@(posedge clk)
    !rst_n |-> in_stall)
    else $error("input not stalled in reset");

  // the pipeline is empty after reset, so no result comes out until a pixel has passed through it
  a_rst_latency: assert property (@(posedge clk)
    !rst_n |=> !out_valid ##1 !out_valid ##1 !out_valid ##1 !out_valid)
    else $error("result too early after reset");

endmodule

bind running_average_background_subtract_top rabs_checker u_rabs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_background (out_background),
  .out_motion     (out_motion),
  .out_overflow   (out_overflow),
  .out_frame_done (out_frame_done)
);

@@ tb/running_average_background_subtract_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_average_background_subtract_checker
// Watches the pixel, result and alpha ports of the background subtraction
// block, keeps its own background store, frame address and alpha, works out
// the background and motion owed for each pixel accepted after the priming
// frame and compares every accepted result against the oldest one still owed.
// ----------------------------------------------------------------------------
module running_average_background_subtract_checker (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  rabs_pkg::pix_t   in_blue,
  input  rabs_pkg::pix_t   in_green,
  input  rabs_pkg::pix_t   in_red,
  input  logic             in_start_of_frame,
  input  logic             in_end_of_frame,
  input  logic             out_valid,
  input  logic             out_stall,
  input  rabs_pkg::pix_t   out_background,
  input  rabs_pkg::pix_t   out_motion,
  input  logic             out_overflow,
  input  logic             out_frame_done,
  input  logic             cfg_wr_en,
  input  rabs_pkg::alpha_t cfg_wr_data,
  output int               mismatches,
  output int               results_owed
);

  typedef struct packed {
    rabs_pkg::pix_t background;
    rabs_pkg::pix_t motion;
    logic           overflow;
    logic           frame_done;
  } bg_result_t;

  bit [7:0]         bg_mem [rabs_pkg::MAX_PIXELS];
  int unsigned      next_addr;
  bit               primed;
  rabs_pkg::alpha_t alpha_setting;
  bg_result_t       owed_q [$];
  bg_result_t       want;
  int               mismatch_total = 0;

  initial begin
    mismatches   = 0;
    results_owed = 0;
  end

  task automatic compare_field(input string field, input logic [7:0] exp_val,
                               input logic [7:0] act_val);
    if (act_val !== exp_val) begin
      mismatch_total++;
      $display("%0t: %s mismatch, expected %0d, actual %0d",
               $time, field, exp_val, act_val);
    end
  endtask

  // advance the background store by one pixel, queueing the result it owes, if any
  task automatic absorb_pixel(input rabs_pkg::pix_t b, g, r, input logic sof, eof);
    int unsigned gray;
    int unsigned addr;
    int unsigned a;
    int unsigned bg_new;
    bit          over;
    bg_result_t  res;
    gray = (32'(b) + 32'(g) + 32'(r)) / 3;
    addr = sof ? 0 : next_addr;
    over = addr >= rabs_pkg::MAX_PIXELS;
    if (!primed) begin
      if (!over)
        bg_mem[addr] = rabs_pkg::pix_t'(gray);
      if (eof)
        primed = 1'b1;
    end else begin
      res = '0;
      if (!over) begin
        a = (alpha_setting > rabs_pkg::ALPHA_ONE) ? 32'(rabs_pkg::ALPHA_ONE)
                                                  : 32'(alpha_setting);
        bg_new = (gray * a + 32'(bg_mem[addr]) * (256 - a)) >> 8;
        bg_mem[addr] = rabs_pkg::pix_t'(bg_new);
        res.background = rabs_pkg::pix_t'(bg_new);
        res.motion = rabs_pkg::pix_t'(gray >= bg_new ? gray - bg_new : bg_new - gray);
      end
      res.overflow   = over;
      res.frame_done = eof;
      owed_q.push_back(res);
    end
    // address saturates at capacity until the frame ends
    if (eof)
      next_addr = 0;
    else if (over)
      next_addr = rabs_pkg::MAX_PIXELS;
    else
      next_addr = addr + 1;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      next_addr     = 0;
      primed        = 1'b0;
      alpha_setting = rabs_pkg::ALPHA_RESET;
      owed_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_q.size() == 0) begin
          mismatch_total++;
          $display("%0t: result with none owed, expected nothing, actual bg %0d motion %0d",
                   $time, out_background, out_motion);
        end else begin
          want = owed_q.pop_front();
          compare_field("background", want.background, out_background);
          compare_field("motion", want.motion, out_motion);
          compare_field("overflow", 8'(want.overflow), 8'(out_overflow));
          compare_field("frame_done", 8'(want.frame_done), 8'(out_frame_done));
        end
      end
      if (cfg_wr_en)
        alpha_setting = cfg_wr_data;
      if (in_valid && !in_stall)
        absorb_pixel(in_blue, in_green, in_red, in_start_of_frame, in_end_of_frame);
    end
    mismatches   <= mismatch_total;
    results_owed <= owed_q.size();
  end

endmodule

@@ tb/running_average_background_subtract_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_average_background_subtract_top_test
// Drives pixel frames and alpha settings into the background subtraction
// block: a priming frame with a restart part way in, tiny frames that
// rewrite an address in flight, short directed frames at the alpha extremes,
// a full frame back to back, then random frames with random gaps and stalls.
// Addresses are kept inside the span that the priming frame wrote.
// The checker beside the block does the prediction and comparison.
// ----------------------------------------------------------------------------
module running_average_background_subtract_top_test;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 860;
  localparam int PRIME_LEN    = 128;
  localparam int DRAIN_CYCLES = 16;
  localparam int CFG_SPACING  = 200;

  typedef enum int {
    CLEAN_FRAME,
    NOISY_FLAGS,
    NO_START,
    RESTART_NO_END
  } frame_shape_e;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  rabs_pkg::pix_t   in_blue = '0;
  rabs_pkg::pix_t   in_green = '0;
  rabs_pkg::pix_t   in_red = '0;
  logic             in_start_of_frame = 1'b0;
  logic             in_end_of_frame = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  rabs_pkg::pix_t   out_background;
  rabs_pkg::pix_t   out_motion;
  logic             out_overflow;
  logic             out_frame_done;
  logic             cfg_wr_en = 1'b0;
  rabs_pkg::alpha_t cfg_wr_data = '0;

  int mismatch_count;
  int results_owed;
  int cycle_count = 0;
  int sink_hold = 0;
  int next_pos = 0;
  bit rush = 1'b0;

  running_average_background_subtract_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_blue           (in_blue),
    .in_green          (in_green),
    .in_red            (in_red),
    .in_start_of_frame (in_start_of_frame),
    .in_end_of_frame   (in_end_of_frame),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_background    (out_background),
    .out_motion        (out_motion),
    .out_overflow      (out_overflow),
    .out_frame_done    (out_frame_done),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  running_average_background_subtract_checker bg_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_blue           (in_blue),
    .in_green          (in_green),
    .in_red            (in_red),
    .in_start_of_frame (in_start_of_frame),
    .in_end_of_frame   (in_end_of_frame),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_background    (out_background),
    .out_motion        (out_motion),
    .out_overflow      (out_overflow),
    .out_frame_done    (out_frame_done),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .mismatches        (mismatch_count),
    .results_owed      (results_owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("running_average_background_subtract_top verification failed");
      $finish;
    end
  end

  // result side: hold off for a random number of cycles after each transaction
  always @(posedge clk) begin
    if (out_valid && !out_stall)
      sink_hold = rush ? 0 : $urandom_range(14, 0);
    else if (sink_hold > 0)
      sink_hold = sink_hold - 1;
    out_stall <= (sink_hold > 0);
  end

  function automatic rabs_pkg::pix_t rand_level();
    case ($urandom_range(7, 0))
      0:       return '0;
      1:       return '1;
      default: return rabs_pkg::pix_t'($urandom_range(255, 0));
    endcase
  endfunction

  task automatic send_pixel(input rabs_pkg::pix_t b, g, r, input logic sof, eof);
    int   gap;
    logic start;
    // restart the frame before the address leaves the primed span
    start    = sof || (next_pos >= PRIME_LEN);
    next_pos = eof ? 0 : (start ? 1 : next_pos + 1);
    gap = rush ? 0 : $urandom_range(14, 0);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_blue           <= b;
    in_green          <= g;
    in_red            <= r;
    in_start_of_frame <= start;
    in_end_of_frame   <= eof;
    do @(posedge clk); while (in_stall);
  endtask

  // one whole frame over the primed span, back to back
  task automatic stream_full_frame();
    int k;
    rush = 1'b1;
    for (k = 0; k < PRIME_LEN; k++)
      send_pixel(rand_level(), rand_level(), rand_level(), k == 0,
                 k == PRIME_LEN - 1);
    rush = 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_alpha(input rabs_pkg::alpha_t value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    int           sent;
    int           next_cfg;
    int           len;
    int           k;
    logic         sof;
    logic         eof;
    frame_shape_e shape;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // priming frame at reset alpha, with a restart part way in
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd254, 1'b0, 1'b0);
    send_pixel(8'd1, 8'd2, 8'd3, 1'b0, 1'b0);
    stream_full_frame();

    // tiny frames back to back so the same address is rewritten in flight
    rush = 1'b1;
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1, 1'b1);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1, 1'b1);
    send_pixel(8'd200, 8'd10, 8'd90, 1'b1, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b0, 1'b1);
    send_pixel(8'd17, 8'd33, 8'd250, 1'b0, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd255, 1'b1, 1'b0);
    send_pixel(8'd128, 8'd127, 8'd129, 1'b0, 1'b1);
    rush = 1'b0;

    drain();
    set_alpha('0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b1);
    drain();
    set_alpha(rabs_pkg::ALPHA_ONE);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b1);
    drain();
    // all ones: above unity, used as unity
    set_alpha('1);
    send_pixel(8'd90, 8'd91, 8'd92, 1'b1, 1'b0);
    send_pixel(8'd3, 8'd4, 8'd5, 1'b0, 1'b1);
    drain();
    set_alpha(rabs_pkg::alpha_t'(257));
    send_pixel(8'd60, 8'd70, 8'd80, 1'b1, 1'b1);
    drain();

    // full frame back to back at half weight
    set_alpha(rabs_pkg::alpha_t'(128));
    stream_full_frame();
    drain();

    sent     = 0;
    next_cfg = CFG_SPACING;
    while (sent < RANDOM_ITEMS) begin
      rush = ($urandom_range(3, 0) == 0);
      case ($urandom_range(9, 0))
        7:       shape = NOISY_FLAGS;
        8:       shape = NO_START;
        9:       shape = RESTART_NO_END;
        default: shape = CLEAN_FRAME;
      endcase
      len = ($urandom_range(4, 0) == 0) ? $urandom_range(64, 9) : $urandom_range(8, 1);
      for (k = 0; k < len; k++) begin
        sof = (k == 0);
        eof = (k == len - 1);
        case (shape)
          NOISY_FLAGS: begin
            sof = ($urandom_range(3, 0) == 0);
            eof = ($urandom_range(3, 0) == 0);
          end
          NO_START: sof = 1'b0;
          RESTART_NO_END: begin
            sof = (k == 0) || (k == len / 2);
            eof = 1'b0;
          end
          default: ;
        endcase
        send_pixel(rand_level(), rand_level(), rand_level(), sof, eof);
      end
      sent += len;
      if (sent >= next_cfg) begin
        next_cfg += CFG_SPACING;
        rush = 1'b0;
        drain();
        case ($urandom_range(5, 0))
          0:       set_alpha('0);
          1:       set_alpha(rabs_pkg::ALPHA_ONE);
          2:       set_alpha('1);
          3:       set_alpha(rabs_pkg::alpha_t'($urandom_range(511, 257)));
          default: set_alpha(rabs_pkg::alpha_t'($urandom_range(255, 1)));
        endcase
      end
    end

    rush = 1'b0;
    drain();
    if (mismatch_count == 0 && results_owed == 0)
      $display("running_average_background_subtract_top verification clean");
    else
      $display("running_average_background_subtract_top verification failed");
    $finish;
  end

endmodule

@@ running_average_background_subtract_top.f @@
rtl/rabs_pkg.sv
rtl/rabs_ram.sv
rtl/running_average_background_subtract_top.sv
rtl/rabs_checker.sv
tb/running_average_background_subtract_checker.sv
tb/running_average_background_subtract_top_test.sv
